/* rtl/gsg_pkg.sv */
// ---------------------------------------------------------------------------
// gsg_pkg
// Types, constants and arithmetic helpers of the Gaussian-sum evaluator.
// ---------------------------------------------------------------------------
package gsg_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_TA,
        ST_TC,
        ST_TW,
        ST_TW2,
        ST_DIV1,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_G,
        ST_P1,
        ST_DIV2,
        ST_P2,
        ST_DIV3,
        ST_WR0,
        ST_WR1,
        ST_WR2,
        ST_EVAL,
        ST_ERD,
        ST_EOUT
    } state_t;

    localparam logic        CFG_MODE  = 1'b0;
    localparam logic        CFG_COUNT = 1'b1;
    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_EVAL   = 1'b1;
    localparam logic        KIND_VAL  = 1'b0;
    localparam logic        KIND_DER  = 1'b1;
    localparam logic [31:0] ONE_Q     = 32'h0001_0000;
    localparam logic [16:0] LOG2E_Q   = 17'd94548;
    localparam logic [32:0] POS_MAX   = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NEG_MAX   = 33'h0_8000_0000;

    typedef struct packed {
        logic        start;
        logic [53:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [32:0] quo;
    } div_rsp_t;

    function automatic logic [16:0] pow2_frac(input logic [4:0] k);
        logic [16:0] r;
        begin
            case (k)
                5'd0:    r = 17'd65536;
                5'd1:    r = 17'd62757;
                5'd2:    r = 17'd60097;
                5'd3:    r = 17'd57549;
                5'd4:    r = 17'd55109;
                5'd5:    r = 17'd52773;
                5'd6:    r = 17'd50535;
                5'd7:    r = 17'd48393;
                5'd8:    r = 17'd46341;
                5'd9:    r = 17'd44376;
                5'd10:   r = 17'd42495;
                5'd11:   r = 17'd40693;
                5'd12:   r = 17'd38968;
                5'd13:   r = 17'd37316;
                5'd14:   r = 17'd35734;
                5'd15:   r = 17'd34219;
                default: r = 17'd32768;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] sat_sm(input logic neg, input logic [32:0] m,
                                           input logic ovf);
        logic [31:0] r;
        begin
            if (neg)
            begin
                if (ovf || m > NEG_MAX)
                    r = 32'h8000_0000;
                else
                    r = ~m[31:0] + 32'd1;
            end
            else
            begin
                if (ovf || m > POS_MAX)
                    r = 32'h7FFF_FFFF;
                else
                    r = m[31:0];
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] sadd(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [31:0] r;
        begin
            s = {a[31], a} + {b[31], b};
            if (s[32] != s[31])
                r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                r = s[31:0];
            return r;
        end
    endfunction

endpackage

/* rtl/gaussian_sum_with_gradient.sv */
// Sequencing: a load is taken while idle; an evaluation runs the term work
//   (up to three divider waits per term, fewer for a dropped term) and then
//   emits its 2+3G or 3+2G results one at a time through the output register.
// Throughput: one item at a time; the next is taken once the last result is
//   in the output register.
// Reset: rst_n clears control, mode to 0 and term count to 1; stores undefined.
// ---------------------------------------------------------------------------
// gaussian_sum_with_gradient
// Sum-of-Gaussians model and its gradient in Q16.16, evaluated term by term
// from a parameter store, with a derivative store drained as a beat stream.
// ---------------------------------------------------------------------------
module gaussian_sum_with_gradient #(
    parameter int MAX_GAUSS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // param_index, param_value, x_coord, pad
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_index, out_value, bad_width, pad
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    localparam int DEPTH = 3 * MAX_GAUSS + 1;
    localparam int AW    = $clog2(DEPTH);

    gsg_pkg::state_t state_reg, state_next;

    logic        mode_reg;
    logic [4:0]  count_reg;
    logic [4:0]  ng_reg;
    logic [5:0]  np_reg;
    logic [31:0] x_reg;
    logic [31:0] vacc_reg;
    logic [31:0] wacc_reg;
    logic [31:0] swid_reg;
    logic        bad_reg;
    logic [4:0]  i_reg;
    logic [5:0]  base_reg;
    logic [31:0] amp_reg;
    logic [31:0] ctr_reg;
    logic [31:0] bmag_reg;
    logic        bneg_reg;
    logic        tneg_reg;
    logic [18:0] tm_reg;
    logic [37:0] tsq_reg;
    logic [21:0] y_reg;
    logic [16:0] e_reg;
    logic [31:0] gmag_reg;
    logic        gneg_reg;
    logic [21:0] t2_reg;
    logic [31:0] dc_reg;
    logic [31:0] dw_reg;
    logic [5:0]  k_reg;

    logic [31:0] pmem [DEPTH];
    logic [31:0] dmem [DEPTH];
    logic [31:0] prd_reg;
    logic [31:0] drd_reg;

    logic        m_valid_reg;
    logic        m_kind_reg;
    logic        m_last_reg;
    logic        m_bad_reg;
    logic [5:0]  m_idx_reg;
    logic [31:0] m_val_reg;

    logic [5:0]  p_raddr;
    logic        d_wen;
    logic [5:0]  d_waddr;
    logic [31:0] d_wdata;
    logic        out_free;
    logic        out_load;

    gsg_pkg::div_req_t div_req;
    gsg_pkg::div_rsp_t div_rsp;

    logic [5:0]  in_idx;
    logic [31:0] in_val;
    logic [31:0] in_x;
    logic [4:0]  ng_clamp;
    logic [31:0] wsel;
    logic        wzero;
    logic [32:0] adiff;
    logic [32:0] amag;
    logic [37:0] ymul;
    logic [16:0] e_calc;
    logic [31:0] amp_mag;
    logic [48:0] gmul;
    logic [50:0] p1mul;
    logic [53:0] p2mul;
    logic        tbig;
    logic [31:0] der_val;
    logic        der_last;

    assign in_idx   = s_axis_tdata[5:0];
    assign in_val   = s_axis_tdata[37:6];
    assign in_x     = s_axis_tdata[69:38];
    assign ng_clamp = (count_reg > 5'(MAX_GAUSS)) ? 5'(MAX_GAUSS) : count_reg;
    assign wsel     = mode_reg ? swid_reg : prd_reg;
    assign wzero    = (wsel == 32'd0);
    assign adiff    = {ctr_reg[31], ctr_reg} - {x_reg[31], x_reg};
    assign amag     = adiff[32] ? (~adiff + 33'd1) : adiff;
    assign ymul     = tsq_reg[37:17] * gsg_pkg::LOG2E_Q;
    assign amp_mag  = amp_reg[31] ? (~amp_reg + 32'd1) : amp_reg;
    assign gmul     = amp_mag * e_reg;
    assign p1mul    = gmag_reg * tm_reg;
    assign p2mul    = gmag_reg * t2_reg;
    assign tbig     = div_rsp.ovf || (div_rsp.quo[32:19] != 14'd0);
    assign der_last = (k_reg == np_reg - 6'd1);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        if (k_reg == 6'd0)
            der_val = gsg_pkg::ONE_Q;
        else if (k_reg == 6'd1 && mode_reg)
            der_val = wacc_reg;
        else
            der_val = drd_reg;
    end

    gsg_exp u_exp (
        .y (y_reg),
        .e (e_calc)
    );

    gsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsg_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tuser == gsg_pkg::OP_EVAL)
                    state_next = gsg_pkg::ST_RD0;
            gsg_pkg::ST_RD0:  state_next = gsg_pkg::ST_RD1;
            gsg_pkg::ST_RD1:  state_next = gsg_pkg::ST_RD2;
            gsg_pkg::ST_RD2:
                state_next = (ng_reg == 5'd0) ? gsg_pkg::ST_EVAL : gsg_pkg::ST_TA;
            gsg_pkg::ST_TA:   state_next = gsg_pkg::ST_TC;
            gsg_pkg::ST_TC:   state_next = gsg_pkg::ST_TW;
            gsg_pkg::ST_TW:   state_next = gsg_pkg::ST_TW2;
            gsg_pkg::ST_TW2:
                state_next = wzero ? gsg_pkg::ST_WR0 : gsg_pkg::ST_DIV1;
            gsg_pkg::ST_DIV1:
                if (div_rsp.done)
                    state_next = tbig ? gsg_pkg::ST_WR0 : gsg_pkg::ST_EXP1;
            gsg_pkg::ST_EXP1: state_next = gsg_pkg::ST_EXP2;
            gsg_pkg::ST_EXP2: state_next = gsg_pkg::ST_EXP3;
            gsg_pkg::ST_EXP3: state_next = gsg_pkg::ST_G;
            gsg_pkg::ST_G:    state_next = gsg_pkg::ST_P1;
            gsg_pkg::ST_P1:   state_next = gsg_pkg::ST_DIV2;
            gsg_pkg::ST_DIV2:
                if (div_rsp.done)
                    state_next = gsg_pkg::ST_P2;
            gsg_pkg::ST_P2:   state_next = gsg_pkg::ST_DIV3;
            gsg_pkg::ST_DIV3:
                if (div_rsp.done)
                    state_next = gsg_pkg::ST_WR0;
            gsg_pkg::ST_WR0:  state_next = gsg_pkg::ST_WR1;
            gsg_pkg::ST_WR1:  state_next = gsg_pkg::ST_WR2;
            gsg_pkg::ST_WR2:
                state_next = (i_reg + 5'd1 == ng_reg) ? gsg_pkg::ST_EVAL : gsg_pkg::ST_TA;
            gsg_pkg::ST_EVAL:
                if (out_free)
                    state_next = gsg_pkg::ST_ERD;
            gsg_pkg::ST_ERD:  state_next = gsg_pkg::ST_EOUT;
            gsg_pkg::ST_EOUT:
                if (out_free)
                    state_next = der_last ? gsg_pkg::ST_IDLE : gsg_pkg::ST_ERD;
            default:          state_next = gsg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        p_raddr       = 6'd0;
        d_wen         = 1'b0;
        d_waddr       = base_reg;
        d_wdata       = {15'd0, e_reg};
        div_req.start = 1'b0;
        div_req.num   = {5'd0, amag, 16'd0};
        div_req.den   = wsel[31] ? (~wsel + 32'd1) : wsel;
        out_load      = 1'b0;
        unique case (state_reg)
            gsg_pkg::ST_IDLE: s_axis_tready = 1'b1;
            gsg_pkg::ST_RD1:  p_raddr = 6'd1;
            gsg_pkg::ST_TA:   p_raddr = base_reg;
            gsg_pkg::ST_TC:   p_raddr = base_reg + 6'd1;
            gsg_pkg::ST_TW:   p_raddr = base_reg + 6'd2;
            gsg_pkg::ST_TW2:  div_req.start = !wzero;
            gsg_pkg::ST_P1:
            begin
                div_req.start = 1'b1;
                div_req.num   = {3'd0, p1mul[50:16], 16'd0};
                div_req.den   = bmag_reg;
            end
            gsg_pkg::ST_P2:
            begin
                div_req.start = 1'b1;
                div_req.num   = {p2mul[53:16], 16'd0};
                div_req.den   = bmag_reg;
            end
            gsg_pkg::ST_WR0:  d_wen = 1'b1;
            gsg_pkg::ST_WR1:
            begin
                d_wen   = 1'b1;
                d_waddr = base_reg + 6'd1;
                d_wdata = dc_reg;
            end
            gsg_pkg::ST_WR2:
            begin
                d_wen   = !mode_reg;
                d_waddr = base_reg + 6'd2;
                d_wdata = dw_reg;
            end
            gsg_pkg::ST_EVAL: out_load = out_free;
            gsg_pkg::ST_EOUT: out_load = out_free;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gsg_pkg::ST_IDLE;
            mode_reg    <= 1'b0;
            count_reg   <= 5'd1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    gsg_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                    gsg_pkg::CFG_COUNT: count_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prd_reg <= pmem[p_raddr[AW-1:0]];
        drd_reg <= dmem[k_reg[AW-1:0]];
        if (state_reg == gsg_pkg::ST_IDLE && s_axis_tvalid
            && s_axis_tuser == gsg_pkg::OP_LOAD && in_idx < 6'(DEPTH))
            pmem[in_idx[AW-1:0]] <= in_val;
        if (d_wen)
            dmem[d_waddr[AW-1:0]] <= d_wdata;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gsg_pkg::ST_IDLE:
            begin
                x_reg  <= in_x;
                ng_reg <= ng_clamp;
                np_reg <= mode_reg ? (6'd2 + {ng_clamp, 1'b0})
                                   : (6'd1 + {1'b0, ng_clamp} + {ng_clamp, 1'b0});
            end
            gsg_pkg::ST_RD1:  vacc_reg <= prd_reg;
            gsg_pkg::ST_RD2:
            begin
                swid_reg <= prd_reg;
                bad_reg  <= mode_reg && prd_reg == 32'd0 && ng_reg != 5'd0;
                wacc_reg <= 32'd0;
                i_reg    <= 5'd0;
                base_reg <= mode_reg ? 6'd2 : 6'd1;
            end
            gsg_pkg::ST_TC:   amp_reg <= prd_reg;
            gsg_pkg::ST_TW:   ctr_reg <= prd_reg;
            gsg_pkg::ST_TW2:
            begin
                bmag_reg <= div_req.den;
                bneg_reg <= wsel[31];
                tneg_reg <= adiff[32] ^ wsel[31];
                if (wzero)
                begin
                    bad_reg  <= 1'b1;
                    e_reg    <= 17'd0;
                    gmag_reg <= 32'd0;
                    dc_reg   <= 32'd0;
                    dw_reg   <= 32'd0;
                end
            end
            gsg_pkg::ST_DIV1:
                if (div_rsp.done)
                begin
                    tm_reg <= div_rsp.quo[18:0];
                    if (tbig)
                    begin
                        e_reg    <= 17'd0;
                        gmag_reg <= 32'd0;
                        dc_reg   <= 32'd0;
                        dw_reg   <= 32'd0;
                    end
                end
            gsg_pkg::ST_EXP1: tsq_reg <= tm_reg * tm_reg;
            gsg_pkg::ST_EXP2: y_reg <= ymul[37:16];
            gsg_pkg::ST_EXP3: e_reg <= e_calc;
            gsg_pkg::ST_G:
            begin
                gmag_reg <= gmul[47:16];
                gneg_reg <= amp_reg[31];
                t2_reg   <= tsq_reg[37:16];
            end
            gsg_pkg::ST_DIV2:
                if (div_rsp.done)
                    dc_reg <= gsg_pkg::sat_sm(!(gneg_reg ^ tneg_reg ^ bneg_reg),
                                              div_rsp.quo, div_rsp.ovf);
            gsg_pkg::ST_DIV3:
                if (div_rsp.done)
                    dw_reg <= gsg_pkg::sat_sm(gneg_reg ^ bneg_reg, div_rsp.quo, div_rsp.ovf);
            gsg_pkg::ST_WR0:
                vacc_reg <= gsg_pkg::sadd(vacc_reg,
                                          gsg_pkg::sat_sm(gneg_reg, {1'b0, gmag_reg}, 1'b0));
            gsg_pkg::ST_WR2:
            begin
                if (mode_reg)
                    wacc_reg <= gsg_pkg::sadd(wacc_reg, dw_reg);
                i_reg    <= i_reg + 5'd1;
                base_reg <= base_reg + (mode_reg ? 6'd2 : 6'd3);
            end
            gsg_pkg::ST_EVAL:
                if (out_free)
                begin
                    k_reg      <= 6'd0;
                    m_kind_reg <= gsg_pkg::KIND_VAL;
                    m_idx_reg  <= 6'd0;
                    m_val_reg  <= vacc_reg;
                    m_bad_reg  <= bad_reg;
                    m_last_reg <= 1'b0;
                end
            gsg_pkg::ST_EOUT:
                if (out_free)
                begin
                    k_reg      <= k_reg + 6'd1;
                    m_kind_reg <= gsg_pkg::KIND_DER;
                    m_idx_reg  <= k_reg;
                    m_val_reg  <= der_val;
                    m_bad_reg  <= bad_reg;
                    m_last_reg <= der_last;
                end
            default:          ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {1'b0, m_bad_reg, m_val_reg, m_idx_reg};

`ifndef NO_ASSERTIONS
    a_last_is_deriv: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == gsg_pkg::KIND_DER)
        else $error("last beat is not a derivative");

    a_value_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == gsg_pkg::KIND_VAL |-> m_axis_tdata[5:0] == 6'd0)
        else $error("model value beat with nonzero index");

    a_dwrite_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_wen |-> d_waddr < 6'(DEPTH))
        else $error("derivative write outside store");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> state_reg == gsg_pkg::ST_DIV1 || state_reg == gsg_pkg::ST_DIV2
                          || state_reg == gsg_pkg::ST_DIV3)
        else $error("divider started outside a wait state");
`endif

endmodule

/* rtl/gsg_div.sv */
// ---------------------------------------------------------------------------
// gsg_div
// Bit-serial restoring divider: 33 quotient bits, one per cycle, with an
// overflow flag when the quotient does not fit.
// ---------------------------------------------------------------------------
module gsg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gsg_pkg::div_req_t req,
    output gsg_pkg::div_rsp_t rsp
);

    logic [32:0] rem_reg;
    logic [32:0] lo_reg;
    logic [32:0] quo_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [32:0] r2;
    logic        ge;

    assign r2 = {rem_reg[31:0], lo_reg[32]};
    assign ge = r2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {12'd0, req.num[53:33]};
            lo_reg  <= req.num[32:0];
            den_reg <= req.den;
            quo_reg <= 33'd0;
            ovf_reg <= {11'd0, req.num[53:33]} >= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (r2 - {1'b0, den_reg}) : r2;
            lo_reg  <= {lo_reg[31:0], 1'b0};
            quo_reg <= {quo_reg[31:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/gsg_exp.sv */
// ---------------------------------------------------------------------------
// gsg_exp
// exp(-arg) from y = arg*log2(e): table of 2^(-k/16), linear interpolation
// and a right shift by the integer part.
// ---------------------------------------------------------------------------
module gsg_exp (
    input  logic [21:0] y,
    output logic [16:0] e
);

    logic [5:0]  n;
    logic [3:0]  j;
    logic [11:0] r;
    logic [16:0] tj;
    logic [16:0] tj1;
    logic [11:0] diff;
    logic [23:0] prod;
    logic [16:0] m;

    always_comb
    begin
        n    = y[21:16];
        j    = y[15:12];
        r    = y[11:0];
        tj   = gsg_pkg::pow2_frac({1'b0, j});
        tj1  = gsg_pkg::pow2_frac({1'b0, j} + 5'd1);
        diff = 12'(tj - tj1);
        prod = diff * r;
        m    = tj - {5'd0, prod[23:12]};
        e    = (n >= 6'd17) ? 17'd0 : (m >> n);
    end

endmodule

/* verif/tb_gaussian_sum_with_gradient.sv */
// ---------------------------------------------------------------------------
// tb_gaussian_sum_with_gradient
// Drives load and evaluate beats into the Gaussian-sum evaluator. A
// behavioral Q16.16 model predicts the value and gradient beats of every
// evaluation, and the monitor checks each output beat against them.
// ---------------------------------------------------------------------------
module tb_gaussian_sum_with_gradient;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NG_MAX   = 16;
    localparam int  DEPTH    = 3 * NG_MAX + 1;
    localparam int  LIMIT    = 3000000;
    localparam longint TLIM  = 8 * 65536;

    typedef struct {
        bit        drain;
        bit        op;
        bit [5:0]  idx;
        bit [31:0] val;
        bit [31:0] x;
    } gauss_item_t;

    typedef struct {
        bit        kind;
        bit [5:0]  idx;
        bit [31:0] val;
        bit        bad;
        bit        last;
    } gauss_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [71:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_user;
    logic        m_last;

    gauss_item_t pending[$];
    gauss_beat_t expected_beats[$];
    int          model_store[DEPTH] = '{default: 0};
    int          shadow[DEPTH] = '{default: 0};
    bit          model_mode;
    bit [4:0]    model_count;
    int          send_idle;
    int          recv_idle;
    int          errors = 0;
    int          cycles = 0;
    bit          in_fire;

    longint pow2_q[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                           32768};

    gaussian_sum_with_gradient u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned umag(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned r;
        r = (umag(a) * umag(b)) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint fx_div(input longint a, input longint b);
        longint unsigned r;
        r = (umag(a) << 16) / umag(b);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic int clip_add(input int a, input int b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic longint exp_neg_q(input longint unsigned arg);
        longint unsigned y;
        longint unsigned n;
        longint unsigned f;
        int              j;
        longint          r;
        y = (arg * 94548) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        j = int'(f >> 12);
        r = longint'(f & 64'hFFF);
        if (n >= 17)
            return 0;
        return (pow2_q[j] - (((pow2_q[j] - pow2_q[j + 1]) * r) >>> 12)) >>> n;
    endfunction

    task automatic gauss_term(input int amp, input int ctr, input int wid, input int x,
                              output longint g, output longint e,
                              output longint dc, output longint dw);
        longint          t;
        longint unsigned tm;
        longint          t2;
        t = fx_div(longint'(ctr) - longint'(x), wid);
        tm = umag(t);
        g = 0;
        e = 0;
        dc = 0;
        dw = 0;
        if (tm < TLIM)
        begin
            e = exp_neg_q((tm * tm) >> 17);
            g = fx_mul(amp, e);
            t2 = fx_mul(t, t);
            dc = -fx_div(fx_mul(g, t), wid);
            dw = fx_div(fx_mul(g, t2), wid);
        end
    endtask

    task automatic predict_gradient(input bit [31:0] xin);
        int          grad[DEPTH];
        int          ng;
        int          np;
        int          acc;
        int          wacc;
        int          wid;
        int          x;
        bit          bad;
        longint      g, e, dc, dw;
        gauss_beat_t b;
        x = xin;
        ng = model_count > NG_MAX ? NG_MAX : model_count;
        bad = 0;
        wacc = 0;
        acc = model_store[0];
        foreach (grad[k])
            grad[k] = 0;
        grad[0] = gsg_pkg::ONE_Q;
        if (!model_mode)
        begin
            np = 1 + 3 * ng;
            for (int i = 0; i < ng; i++)
            begin
                wid = model_store[3 * i + 3];
                if (wid == 0)
                    bad = 1;
                else
                begin
                    gauss_term(model_store[3 * i + 1], model_store[3 * i + 2], wid, x,
                               g, e, dc, dw);
                    acc = clip_add(acc, clip32(g));
                    grad[3 * i + 1] = clip32(e);
                    grad[3 * i + 2] = clip32(dc);
                    grad[3 * i + 3] = clip32(dw);
                end
            end
        end
        else
        begin
            np = 2 + 2 * ng;
            wid = model_store[1];
            if (wid == 0 && ng > 0)
                bad = 1;
            for (int i = 0; i < ng && wid != 0; i++)
            begin
                gauss_term(model_store[2 * i + 2], model_store[2 * i + 3], wid, x,
                           g, e, dc, dw);
                acc = clip_add(acc, clip32(g));
                grad[2 * i + 2] = clip32(e);
                grad[2 * i + 3] = clip32(dc);
                wacc = clip_add(wacc, clip32(dw));
            end
            grad[1] = wacc;
        end
        b = '{gsg_pkg::KIND_VAL, 6'd0, acc, bad, 1'b0};
        expected_beats.push_back(b);
        for (int k = 0; k < np; k++)
        begin
            b = '{gsg_pkg::KIND_DER, k[5:0], grad[k], bad, k + 1 == np};
            expected_beats.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR at cycle %0d: %s", cycles, msg);
    endtask

    task automatic push_load(input int idx, input bit [31:0] val);
        gauss_item_t it;
        it = '{1'b0, gsg_pkg::OP_LOAD, idx[5:0], val, $urandom};
        pending.push_back(it);
    endtask

    task automatic push_eval(input bit [31:0] x);
        gauss_item_t it;
        it = '{1'b0, gsg_pkg::OP_EVAL, 6'($urandom), $urandom, x};
        pending.push_back(it);
    endtask

    task automatic push_drain();
        gauss_item_t it;
        it = '{1'b1, 1'b0, 6'd0, 32'd0, 32'd0};
        pending.push_back(it);
    endtask

    function automatic bit [31:0] rand_fix();
        int v;
        if ($urandom_range(7) == 0)
            return $urandom;
        v = $urandom_range(1 << 20);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic bit [31:0] rand_width();
        int v;
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom;
            default:
            begin
                v = $urandom_range(1 << 20, 1 << 8);
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    function automatic bit is_width(input int idx);
        return model_mode ? idx == 1 : (idx > 0 && idx % 3 == 0);
    endfunction

    function automatic int model_store_pick();
        return shadow[$urandom_range(DEPTH - 1)];
    endfunction

    task automatic wait_idle();
        wait (pending.size() == 0 && expected_beats.size() == 0 && !s_valid);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input bit [4:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == gsg_pkg::CFG_MODE)
            model_mode = val[0];
        else
            model_count = val;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic run_phase(input bit mode, input bit [4:0] count, input int n);
        int ng;
        int np;
        int idx;
        wait_idle();
        write_cfg(gsg_pkg::CFG_MODE, {4'd0, mode});
        write_cfg(gsg_pkg::CFG_COUNT, count);
        ng = count > NG_MAX ? NG_MAX : count;
        np = mode ? 2 + 2 * ng : 1 + 3 * ng;
        for (int k = 0; k < np; k++)
            push_load(k, is_width(k) ? rand_width() : rand_fix());
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
                push_drain();
            if ($urandom_range(3) == 0)
            begin
                idx = $urandom_range(63);
                push_load(idx, is_width(idx) ? rand_width() : rand_fix());
            end
            else if ($urandom_range(9) == 0)
                push_eval($urandom);
            else
                push_eval(model_store_pick() + $urandom_range(1 << 18) - (1 << 17));
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("gaussian_sum_with_gradient test failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready)
            begin
                if (s_user == gsg_pkg::OP_LOAD)
                begin
                    if (s_data[5:0] < DEPTH)
                        model_store[s_data[5:0]] = s_data[37:6];
                end
                else
                    predict_gradient(s_data[69:38]);
            end
        end
    end

    always @(negedge clk)
    begin
        gauss_item_t it;
        bit          nv;
        if (rst_n && (!s_valid || in_fire))
        begin
            nv = 1'b0;
            if (pending.size() > 0 && pending[0].drain)
            begin
                if (expected_beats.size() == 0)
                    void'(pending.pop_front());
            end
            else if (pending.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                it = pending.pop_front();
                s_data <= {2'b00, it.x, it.val, it.idx};
                s_user <= it.op;
                if (it.op == gsg_pkg::OP_LOAD && it.idx < DEPTH)
                    shadow[it.idx] = it.val;
                nv = 1'b1;
            end
            s_valid <= nv;
        end
        if (rst_n)
            m_ready <= $urandom_range(99) >= recv_idle;
    end

    always @(posedge clk)
    begin
        gauss_beat_t b;
        if (rst_n && m_valid && m_ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", m_data));
            else
            begin
                b = expected_beats.pop_front();
                if (m_user != b.kind || m_data[5:0] != b.idx || m_data[37:6] != b.val
                    || m_data[38] != b.bad || m_last != b.last)
                    report_mismatch($sformatf(
                        "got k%0b i%0d v%h b%0b l%0b, want k%0b i%0d v%h b%0b l%0b",
                        m_user, m_data[5:0], m_data[37:6], m_data[38], m_last,
                        b.kind, b.idx, b.val, b.bad, b.last));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 5'd0;
        model_mode = 1'b0;
        model_count = 5'd1;
        send_idle = 10;
        recv_idle = 83;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < DEPTH; k++)
            push_load(k, (k > 0 && k % 3 == 0) ? 32'(gsg_pkg::ONE_Q) : 32'd0);
        push_load(1, gsg_pkg::ONE_Q);
        push_eval(32'd0);
        push_eval(gsg_pkg::ONE_Q);
        push_eval(32'h8000_0000);
        push_eval(32'h7FFF_FFFF);
        push_load(0, 32'h7FFF_FFFF);
        push_load(1, 32'h7FFF_FFFF);
        push_eval(32'd0);
        push_load(0, 32'h8000_0000);
        push_load(1, 32'h8000_0000);
        push_eval(32'd0);
        push_load(3, 32'd0);
        push_eval(32'd0);
        push_load(3, 32'd1);
        push_eval(gsg_pkg::ONE_Q);
        push_load(3, -32'(gsg_pkg::ONE_Q));
        push_load(1, gsg_pkg::ONE_Q);
        push_eval(gsg_pkg::ONE_Q >> 1);
        push_load(63, 32'hFFFF_FFFF);
        push_load(49, 32'h5555_AAAA);
        push_eval(32'hFFFF_0000);

        run_phase(1'b0, 5'd2, 15);
        run_phase(1'b1, 5'd3, 15);
        run_phase(1'b0, 5'd0, 10);
        send_idle = 83;
        recv_idle = 10;
        run_phase(1'b1, 5'd0, 10);
        run_phase(1'b1, 5'd16, 10);
        run_phase(1'b0, 5'd16, 10);
        send_idle = 0;
        recv_idle = 0;
        run_phase(1'b0, 5'd31, 10);
        run_phase(1'b1, 5'd4, 15);
        run_phase(1'b0, 5'd5, 15);
        wait_idle();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("gaussian_sum_with_gradient test passed");
        else
            $display("gaussian_sum_with_gradient test failed");
        $finish;
    end

endmodule
